/* hdl/pwts_pkg.sv */
// Package for the perspective world-to-screen block: widths, register
// indexes and pipeline depths. No dependencies.
`default_nettype none
package pwts_pkg;
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int PROD_W    = 2 * COORD_W - FRAC_BITS;
  localparam int CLIP_W    = PROD_W + 1;
  localparam int SCR_W     = 14;
  localparam int A_W       = CLIP_W + SCR_W;
  localparam int WD_W      = CLIP_W - 1;
  localparam int Q_W       = 18;
  localparam int CMP_W     = WD_W + Q_W;
  localparam int DIV_ST    = Q_W + 1;
  localparam int N_ST      = DIV_ST + 4;
  localparam int PIX_W     = 16;
  localparam int NEAR_THR  = (1 << FRAC_BITS) / 1000;
  localparam int N_COEF    = 6;
  localparam int CFG_IDX_W = 4;
  localparam logic [SCR_W-1:0] WIDTH_RST  = SCR_W'(1920);
  localparam logic [SCR_W-1:0] HEIGHT_RST = SCR_W'(1080);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_AB   = 4'd0,
    REG_X_CD   = 4'd1,
    REG_Y_AB   = 4'd2,
    REG_Y_CD   = 4'd3,
    REG_W_AB   = 4'd4,
    REG_W_CD   = 4'd5,
    REG_WIDTH  = 4'd6,
    REG_HEIGHT = 4'd7
  } cfg_idx_e;

  typedef logic [63:0] coef_t [N_COEF];
endpackage
`default_nettype wire

/* hdl/perspective_world_to_screen.sv */
// Perspective world-to-screen projection, top level.
// Uses pwts_pkg, pwts_clip and pwts_div.
//
// Input stream s_axis: one world point per item (x, y, z, signed Q16.16).
// Output stream m_axis: one result per item: visible flag, pixel column
// and pixel row (signed 16 bit, floored, saturated; 0 when not visible).
// Config channel cfg_*: index 0..7 selects a register, data is written
// at the cfg_valid_i edge; cfg_ready_o is always high. Write only while
// no item is in flight. Indexes above 7 are ignored.
// Depth: 23 register stages. Throughput: one item per cycle while
// m_axis_tready is high; depth is set by the 18
// quotient-bit stages of the two dividers plus product, sum, scale,
// overflow and output stages.
// Reset clears all valid bits and restores the registers (coefficients
// 0, width 1920, height 1080). When m_axis_tready is low, items close up
// into empty stages; once every stage is full, s_axis_tready drops and
// nothing is lost or repeated.
`default_nettype none
module perspective_world_to_screen (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // pos_x [31:0], pos_y [63:32], pos_z [95:64]
  input  wire logic [95:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // visible [0], screen_x [16:1], screen_y [32:17], zero [39:33]
  output logic [39:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [pwts_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);
  import pwts_pkg::*;

  coef_t            coef_q;
  logic [SCR_W-1:0] width_q, height_q;
  logic [N_ST-1:0]  v_q, en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N_COEF; k++) coef_q[k] <= '0;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_X_AB:   coef_q[0] <= cfg_data_i;
        REG_X_CD:   coef_q[1] <= cfg_data_i;
        REG_Y_AB:   coef_q[2] <= cfg_data_i;
        REG_Y_CD:   coef_q[3] <= cfg_data_i;
        REG_W_AB:   coef_q[4] <= cfg_data_i;
        REG_W_CD:   coef_q[5] <= cfg_data_i;
        REG_WIDTH:  width_q   <= cfg_data_i[SCR_W-1:0];
        REG_HEIGHT: height_q  <= cfg_data_i[SCR_W-1:0];
        default: ;
      endcase
    end
  end

  // per-stage enable: a stage loads when empty or when its successor loads
  always_comb begin
    en[N_ST-1] = !v_q[N_ST-1] || m_axis_tready;
    for (int k = N_ST - 2; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= s_axis_tvalid;
      for (int k = 1; k < N_ST; k++) if (en[k]) v_q[k] <= v_q[k-1];
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v_q[N_ST-1];

  logic signed [CLIP_W-1:0] clip_x, clip_y, clip_w;

  pwts_clip u_clip (
    .clk_i    (clk_i),
    .en_i     (en[1:0]),
    .pos_x_i  (s_axis_tdata[31:0]),
    .pos_y_i  (s_axis_tdata[63:32]),
    .pos_z_i  (s_axis_tdata[95:64]),
    .coef_i   (coef_q),
    .clip_x_o (clip_x),
    .clip_y_o (clip_y),
    .clip_w_o (clip_w)
  );

  // scale stage: magnitudes times screen size, sign and visibility
  logic [A_W-1:0]  ax_q, ay_q;
  logic            nx_q, ny_q;
  logic [WD_W-1:0] den_q;
  logic            vis_q [DIV_ST+1];
  logic [CLIP_W-1:0] mag_x, mag_y;
  logic            vis_d;

  assign mag_x = clip_x[CLIP_W-1] ? CLIP_W'(-clip_x) : CLIP_W'(clip_x);
  assign mag_y = clip_y[CLIP_W-1] ? CLIP_W'(-clip_y) : CLIP_W'(clip_y);
  assign vis_d = clip_w > CLIP_W'(NEAR_THR);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      ax_q     <= A_W'(mag_x) * A_W'(width_q);
      ay_q     <= A_W'(mag_y) * A_W'(height_q);
      nx_q     <= clip_x[CLIP_W-1];
      ny_q     <= !clip_y[CLIP_W-1] && (clip_y != '0);
      den_q    <= vis_d ? clip_w[WD_W-1:0] : WD_W'(1);
      vis_q[0] <= vis_d;
    end
    for (int j = 1; j <= DIV_ST; j++) if (en[2+j]) vis_q[j] <= vis_q[j-1];
  end

  logic [Q_W-1:0] qx, qy;
  logic nzx, nzy, ovx, ovy, sgx, sgy;

  pwts_div u_div_x (
    .clk_i (clk_i), .en_i (en[DIV_ST+2:3]),
    .num_i (ax_q), .den_i (den_q), .neg_i (nx_q),
    .quo_o (qx), .rem_nz_o (nzx), .ovf_o (ovx), .neg_o (sgx)
  );

  pwts_div u_div_y (
    .clk_i (clk_i), .en_i (en[DIV_ST+2:3]),
    .num_i (ay_q), .den_i (den_q), .neg_i (ny_q),
    .quo_o (qy), .rem_nz_o (nzy), .ovf_o (ovy), .neg_o (sgy)
  );

  function automatic logic [PIX_W-1:0] pix(input logic [Q_W-1:0] q,
      input logic nz, input logic ovf, input logic neg,
      input logic [SCR_W-1:0] s);
    logic signed [Q_W+2:0] f;
    logic signed [Q_W+2:0] b;
    logic signed [Q_W+2:0] h;
    f = (Q_W+3)'(q) + (Q_W+3)'(neg && nz);
    if (neg) f = -f;
    b = f + (Q_W+3)'(s) + (Q_W+3)'(1);
    h = b >>> 1;
    if (ovf) pix = neg ? PIX_W'(16'h8000) : PIX_W'(16'h7fff);
    else if (h > (Q_W+3)'(32767)) pix = PIX_W'(16'h7fff);
    else if (h < -(Q_W+3)'(32768)) pix = PIX_W'(16'h8000);
    else pix = h[PIX_W-1:0];
  endfunction

  logic             ovis_q;
  logic [PIX_W-1:0] ox_q, oy_q;

  always_ff @(posedge clk_i) begin
    if (en[N_ST-1]) begin
      ovis_q <= vis_q[DIV_ST];
      ox_q   <= vis_q[DIV_ST] ? pix(qx, nzx, ovx, sgx, width_q) : '0;
      oy_q   <= vis_q[DIV_ST] ? pix(qy, nzy, ovy, sgy, height_q) : '0;
    end
  end

  assign m_axis_tdata = {7'd0, oy_q, ox_q, ovis_q};
endmodule
`default_nettype wire

/* hdl/pwts_clip.sv */
// Clip-space transform: nine floored products, then the three row sums.
// Uses pwts_pkg.
`default_nettype none
module pwts_clip (
  input  wire logic                                   clk_i,
  input  wire logic [1:0]                             en_i,
  input  wire logic signed [pwts_pkg::COORD_W-1:0]    pos_x_i,
  input  wire logic signed [pwts_pkg::COORD_W-1:0]    pos_y_i,
  input  wire logic signed [pwts_pkg::COORD_W-1:0]    pos_z_i,
  input  wire pwts_pkg::coef_t                        coef_i,
  output logic signed [pwts_pkg::CLIP_W-1:0]          clip_x_o,
  output logic signed [pwts_pkg::CLIP_W-1:0]          clip_y_o,
  output logic signed [pwts_pkg::CLIP_W-1:0]          clip_w_o
);
  import pwts_pkg::*;

  logic signed [PROD_W-1:0] prod_d [9];
  logic signed [PROD_W-1:0] prod_q [9];
  logic signed [CLIP_W-1:0] sum_d [3];
  logic signed [CLIP_W-1:0] sum_q [3];

  always_comb begin
    logic signed [2*COORD_W-1:0] full;
    logic signed [COORD_W-1:0]   cf;
    logic signed [COORD_W-1:0]   pv;
    for (int k = 0; k < 9; k++) begin
      case (k % 3)
        0:       begin cf = coef_i[2*(k/3)][31:0];    pv = pos_x_i; end
        1:       begin cf = coef_i[2*(k/3)][63:32];   pv = pos_y_i; end
        default: begin cf = coef_i[2*(k/3)+1][31:0];  pv = pos_z_i; end
      endcase
      full = cf * pv;
      prod_d[k] = full[2*COORD_W-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) prod_q <= prod_d;
  end

  always_comb begin
    logic signed [COORD_W-1:0] ofs;
    for (int r = 0; r < 3; r++) begin
      ofs = coef_i[2*r+1][63:32];
      sum_d[r] = CLIP_W'(prod_q[3*r]) + CLIP_W'(prod_q[3*r+1])
               + CLIP_W'(prod_q[3*r+2]) + CLIP_W'(ofs);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) sum_q <= sum_d;
  end

  assign clip_x_o = sum_q[0];
  assign clip_y_o = sum_q[1];
  assign clip_w_o = sum_q[2];
endmodule
`default_nettype wire

/* hdl/pwts_div.sv */
// Pipelined restoring divider: overflow check, then one quotient bit per
// stage. Uses pwts_pkg.
`default_nettype none
module pwts_div (
  input  wire logic                         clk_i,
  input  wire logic [pwts_pkg::DIV_ST-1:0]  en_i,
  input  wire logic [pwts_pkg::A_W-1:0]     num_i,
  input  wire logic [pwts_pkg::WD_W-1:0]    den_i,
  input  wire logic                         neg_i,
  output logic [pwts_pkg::Q_W-1:0]          quo_o,
  output logic                              rem_nz_o,
  output logic                              ovf_o,
  output logic                              neg_o
);
  import pwts_pkg::*;

  logic [A_W-1:0]  rem_q [DIV_ST];
  logic [Q_W-1:0]  quo_q [DIV_ST];
  logic [WD_W-1:0] den_q [DIV_ST];
  logic            ovf_q [DIV_ST];
  logic            neg_q [DIV_ST];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= num_i;
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      neg_q[0] <= neg_i;
      ovf_q[0] <= CMP_W'(num_i) >= (CMP_W'(den_i) << Q_W);
    end
  end

  for (genvar j = 1; j < DIV_ST; j++) begin : g_bit
    logic [CMP_W-1:0] shd;
    logic             take;
    assign shd  = CMP_W'(den_q[j-1]) << (Q_W - j);
    assign take = CMP_W'(rem_q[j-1]) >= shd;
    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q[j] <= take ? A_W'(CMP_W'(rem_q[j-1]) - shd) : rem_q[j-1];
        quo_q[j] <= quo_q[j-1] | (Q_W'(take) << (Q_W - j));
        den_q[j] <= den_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
        neg_q[j] <= neg_q[j-1];
      end
    end
  end

  assign quo_o    = quo_q[DIV_ST-1];
  assign rem_nz_o = |rem_q[DIV_ST-1];
  assign ovf_o    = ovf_q[DIV_ST-1];
  assign neg_o    = neg_q[DIV_ST-1];
endmodule
`default_nettype wire

/* hdl/pwts_checker.sv */
// Port-level checks for perspective_world_to_screen, bound to the top.
// Depends on the top level's ports only.
`default_nettype none
module pwts_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item dropped under stall");

  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[32:1] == 32'd0)
    else $error("hidden point with nonzero coordinates");

  a_rst: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");
endmodule

bind perspective_world_to_screen pwts_checker u_pwts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

/* sim/pwts_checker.sv */
// Checker for perspective_world_to_screen: tracks register writes, predicts
// each projected point from the accepted input items and compares results.
// Depends on pwts_pkg.
`default_nettype none
module pwts_tb_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [39:0] m_axis_tdata,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_o,
  input  wire logic [pwts_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  output int               fail_count_o,
  output int               pending_o
);
  import pwts_pkg::*;

  logic [63:0] coef_q [N_COEF];
  logic [13:0] width_q, height_q;
  logic [39:0] pixel_q [$];

  assign pending_o = pixel_q.size();

  function automatic longint floor_sh(longint v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic longint clip_row(int r, longint px, longint py, longint pz);
    longint a, b, c, d;
    a = longint'($signed(coef_q[2*r][31:0]));
    b = longint'($signed(coef_q[2*r][63:32]));
    c = longint'($signed(coef_q[2*r+1][31:0]));
    d = longint'($signed(coef_q[2*r+1][63:32]));
    return floor_sh(a * px) + floor_sh(b * py) + floor_sh(c * pz) + d;
  endfunction

  // floor((S + 1 + num*S/w) / 2) with exact remainder handling, saturated
  function automatic logic [15:0] pixel_of(longint num, longint w, longint s);
    longint q, r, k, res;
    q = num / w;
    if (num % w != 0 && num < 0) q--;
    r = num - q * w;
    k = (r * s) / w;
    if (q > 1048576) q = 1048576;
    if (q < -1048576) q = -1048576;
    res = (q * s + s + 1 + k) >>> 1;
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    return res[15:0];
  endfunction

  function automatic logic [39:0] project(logic [95:0] d);
    longint px, py, pz, cx, cy, cw;
    px = longint'($signed(d[31:0]));
    py = longint'($signed(d[63:32]));
    pz = longint'($signed(d[95:64]));
    cx = clip_row(0, px, py, pz);
    cy = clip_row(1, px, py, pz);
    cw = clip_row(2, px, py, pz);
    if (cw <= NEAR_THR) return '0;
    return {7'd0, pixel_of(-cy, cw, longint'(height_q)),
            pixel_of(cx, cw, longint'(width_q)), 1'b1};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [39:0] exp_v;
    if (!rst_ni) begin
      for (int i = 0; i < N_COEF; i++) coef_q[i] <= '0;
      width_q <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      fail_count_o <= 0;
      pixel_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_WIDTH) width_q <= cfg_data_i[13:0];
        else if (cfg_index_i == REG_HEIGHT) height_q <= cfg_data_i[13:0];
        else if (cfg_index_i < N_COEF) coef_q[cfg_index_i] <= cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) pixel_q.push_back(project(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixel_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result %h", m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_v = pixel_q.pop_front();
          if (exp_v !== m_axis_tdata) begin
            if (fail_count_o < 10)
              $display("mismatch: vis %b/%b x %0d/%0d y %0d/%0d", exp_v[0],
                       m_axis_tdata[0], $signed(exp_v[16:1]),
                       $signed(m_axis_tdata[16:1]), $signed(exp_v[32:17]),
                       $signed(m_axis_tdata[32:17]));
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

/* sim/perspective_world_to_screen_tb.sv */
// Testbench top for perspective_world_to_screen: drives register writes, and points
// with random gaps under random stalls; pwts_tb_checker predicts and compares.
// Depends on pwts_pkg, pwts_tb_checker and the block RTL.
`default_nettype none
module perspective_world_to_screen_tb;
  import pwts_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED = 4'd8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  int fail_count, pending, idle_cycles;
  bit sink_gaps = 1'b1;

  always #5 clk_i = ~clk_i;

  perspective_world_to_screen dut (.*);

  pwts_tb_checker u_checker (.*, .fail_count_o(fail_count), .pending_o(pending));

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side stalls
  initial begin
    int gap;
    forever begin
      gap = sink_gaps ? $urandom_range(0, 4) : 0;
      repeat (gap) @(posedge clk_i) m_axis_tready <= 1'b0;
      @(posedge clk_i) m_axis_tready <= 1'b1;
      while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk_i);
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 200 * 65536)) - 100 * 65536);
      default: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
    endcase
  endfunction

  // perspective-like setup: w driven by z with random scaling; wild gives random coefficients
  task automatic setup_camera(logic [13:0] w, logic [13:0] h, bit wild);
    if (wild) begin
      write_reg(REG_X_AB, {$urandom(), $urandom()});
      write_reg(REG_X_CD, {$urandom(), $urandom()});
      write_reg(REG_Y_AB, {$urandom(), $urandom()});
      write_reg(REG_Y_CD, {$urandom(), $urandom()});
      write_reg(REG_W_AB, {$urandom(), $urandom()});
      write_reg(REG_W_CD, {$urandom(), $urandom()});
    end else begin
      write_reg(REG_X_AB, {32'($urandom_range(0, 4096)), 32'($urandom_range(1, 3) << 16)});
      write_reg(REG_X_CD, {32'($urandom_range(0, 65536)), 32'($urandom_range(0, 8192))});
      write_reg(REG_Y_AB, {32'($urandom_range(1, 3) << 16), 32'($urandom_range(0, 4096))});
      write_reg(REG_Y_CD, {32'($urandom_range(0, 65536)), 32'($urandom_range(0, 8192))});
      write_reg(REG_W_AB, {32'($urandom_range(0, 2048)), 32'($urandom_range(0, 2048))});
      write_reg(REG_W_CD, {32'($urandom_range(0, 65536)), ONE});
    end
    write_reg(REG_WIDTH, 64'(w));
    write_reg(REG_HEIGHT, 64'(h));
  endtask

  initial begin
    logic [31:0] z;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: identity-like camera, z as w
    write_reg(REG_X_AB, {32'd0, ONE});
    write_reg(REG_X_CD, '0);
    write_reg(REG_Y_AB, {ONE, 32'd0});
    write_reg(REG_Y_CD, '0);
    write_reg(REG_W_AB, '0);
    write_reg(REG_W_CD, {32'd0, ONE});
    write_reg(cfg_idx_e'(IDX_UNUSED), 64'hFFFF);
    send_point(0, 0, ONE, 1);
    send_point(ONE, ONE, ONE, 1);
    send_point(32'hFFFF_0000, 32'hFFFF_0000, ONE, 1);
    send_point(0, 0, 32'd65, 1);
    send_point(0, 0, 32'd66, 1);
    send_point(ONE, 0, 32'd66, 1);
    send_point(0, 0, 0, 1);
    send_point(0, 0, 32'h8000_0000, 1);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'd1000, 1);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd100, 1);
    send_point(32'h0000_8000, 32'hFFFF_8000, ONE, 1);
    s_axis_tvalid <= 1'b0;
    drain();
    setup_camera(14'd1, 14'd1, 0);
    for (int i = 0; i < 5; i++) send_point(rand_coord(2), rand_coord(2), rand_coord(2), 1);
    s_axis_tvalid <= 1'b0;
    drain();
    setup_camera(14'd8192, 14'd16383, 0);
    for (int i = 0; i < 5; i++) send_point(rand_coord(1), rand_coord(1), rand_coord(1), 1);
    s_axis_tvalid <= 1'b0;
    drain();
    setup_camera(14'd0, 14'd0, 1);
    for (int i = 0; i < 3; i++) send_point($urandom(), $urandom(), $urandom(), 1);
    s_axis_tvalid <= 1'b0;
    drain();

    // random phases
    for (int p = 0; p < 11; p++) begin
      setup_camera(p % 4 == 0 ? 14'($urandom_range(0, 16383))
                              : 14'($urandom_range(1, 8192)),
                   14'($urandom_range(1, 8192)), p % 5 == 4);
      sink_gaps = (p % 3 != 2);
      for (int i = 0; i < 100; i++) begin
        z = ($urandom_range(0, 9) == 0) ? rand_coord(0)
                                        : 32'($urandom_range(0, 64 * 65536));
        send_point(rand_coord($urandom_range(0, 9) == 0 ? 0 : 1),
                   rand_coord($urandom_range(0, 9) == 0 ? 0 : 2), z, p % 3 != 1);
      end
      s_axis_tvalid <= 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
hdl/pwts_pkg.sv
hdl/pwts_clip.sv
hdl/pwts_div.sv
hdl/perspective_world_to_screen.sv
hdl/pwts_checker.sv
sim/pwts_checker.sv
sim/perspective_world_to_screen_tb.sv
